// ===== design/bbs_pkg.sv =====
// ----------------------------------------------------------------------------
// bbs_pkg: shared types and constants of the biquad bandpass bank
// Field widths, operation codes and the sequencer-to-MAC control struct.
// ----------------------------------------------------------------------------
`default_nettype none

package bbs_pkg;

  localparam int OP_W      = 1;
  localparam int IDX_IN_W  = 4;
  localparam int COEF_W    = 18;
  localparam int SAMPLE_W  = 16;
  localparam int YHIST_W   = 20;
  localparam int SUM_W     = 24;
  localparam int ACT_W     = 5;

  // Shared multiplier operand widths: A holds a coefficient or its negation,
  // B holds a sample or an output history value.
  localparam int MUL_A_W   = COEF_W + 1;
  localparam int MUL_B_W   = YHIST_W;

  localparam logic [OP_W-1:0] OP_LOAD = 1'b0;
  localparam logic [OP_W-1:0] OP_PROC = 1'b1;

  localparam logic [ACT_W-1:0] ACTIVE_RESET = 5'd1;

  typedef struct packed {
    logic mul_en;   // register a new product
    logic acc_clr;  // clear the section accumulator
    logic acc_en;   // add the rounded product to the accumulator
    logic acc_sub;  // subtract instead of add
  } mac_ctrl_t;

endpackage

`default_nettype wire

// ===== design/bbs_ifs.sv =====
// ----------------------------------------------------------------------------
// bbs_ifs: valid/ready channels of the biquad bandpass bank
// Request channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface bbs_in_if;
  logic                                valid;
  logic                                ready;
  logic [bbs_pkg::OP_W-1:0]            op;
  logic [bbs_pkg::IDX_IN_W-1:0]        filter_index;
  logic signed [bbs_pkg::COEF_W-1:0]   coef_b0;
  logic signed [bbs_pkg::COEF_W-1:0]   coef_a1;
  logic signed [bbs_pkg::COEF_W-1:0]   coef_a2;
  logic signed [bbs_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, op, filter_index, coef_b0, coef_a1, coef_a2, sample,
                  input ready);
  modport sink   (input valid, op, filter_index, coef_b0, coef_a1, coef_a2, sample,
                  output ready);
endinterface

interface bbs_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [bbs_pkg::SUM_W-1:0]  bank_sum;

  modport source (output valid, bank_sum, input ready);
  modport sink   (input valid, bank_sum, output ready);
endinterface

interface bbs_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bbs_pkg::ACT_W-1:0]       data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== design/biquad_bandpass_bank_sum_top.sv =====
// ----------------------------------------------------------------------------
// biquad_bandpass_bank_sum_top: bank of bandpass biquads with summed output
// Coefficient loads and sample requests share one channel; one shared MAC
// steps through the active sections under a small sequencer.
// ----------------------------------------------------------------------------
// Timing: a coefficient load is taken while idle and yields no result.
//   A sample request with n active sections (active_filters clamped to
//   NUM_FILTERS) raises result valid once all n sections have run.
// Throughput: one load per cycle while idle; a new sample is taken only
//   once the last sum is posted. The single multiplier takes, per section,
//   an address step, four products, a last accumulate, a history write-back.
// Reset: tables and histories read as zero through per-entry valid bits,
//   active_filters returns to 1; no clearing pass is needed.
`default_nettype none

module biquad_bandpass_bank_sum_top #(
  parameter int NUM_FILTERS    = 16,
  parameter int COEF_FRAC_BITS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bbs_in_if.sink    item_i,
  bbs_out_if.source result_o,
  bbs_cfg_if.sink   cfg_i
);

  localparam int IDXW   = (NUM_FILTERS > 1) ? $clog2(NUM_FILTERS) : 1;
  localparam int CNTW   = $clog2(NUM_FILTERS + 1);
  localparam int COEF_W = bbs_pkg::COEF_W;
  localparam int YW     = bbs_pkg::YHIST_W;
  localparam int SW     = bbs_pkg::SUM_W;
  localparam int AW     = bbs_pkg::MUL_A_W;
  localparam int BW     = bbs_pkg::MUL_B_W;
  localparam int CWORD  = 3 * COEF_W;
  localparam int HWORD  = 2 * YW;
  localparam int SACCW  = (YW + CNTW > SW) ? (YW + CNTW) : SW;

  localparam logic signed [SACCW-1:0] SUM_MAX = SACCW'((64'sd1 <<< (SW - 1)) - 64'sd1);
  localparam logic signed [SACCW-1:0] SUM_MIN = SACCW'(-(64'sd1 <<< (SW - 1)));

  // Sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ADDR = 3'd1;
  localparam logic [2:0] ST_MAC  = 3'd2;
  localparam logic [2:0] ST_FIN  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  // MAC steps within one section
  localparam logic [2:0] TERM_X   = 3'd0;  // b0 * x
  localparam logic [2:0] TERM_X2  = 3'd1;  // -b0 * x[n-2]
  localparam logic [2:0] TERM_Y1  = 3'd2;  // a1 * y[n-1]
  localparam logic [2:0] TERM_Y2  = 3'd3;  // a2 * y[n-2]
  localparam logic [2:0] TERM_END = 3'd4;  // last accumulate only

  logic [2:0]                    state_q, state_d;
  logic [CNTW-1:0]               k_q, k_d;
  logic [CNTW-1:0]               n_q, n_d;
  logic [2:0]                    term_q, term_d;
  logic signed [bbs_pkg::SAMPLE_W-1:0] x_q, x_d;
  logic signed [bbs_pkg::SAMPLE_W-1:0] xh1_q, xh1_d;
  logic signed [bbs_pkg::SAMPLE_W-1:0] xh2_q, xh2_d;
  logic signed [SACCW-1:0]       sum_q, sum_d;
  logic                          out_valid_q, out_valid_d;
  logic signed [SW-1:0]          bank_sum_q, bank_sum_d;
  logic [bbs_pkg::ACT_W-1:0]     active_q, active_d;
  logic [NUM_FILTERS-1:0]        coef_vld_q, coef_vld_d;
  logic [NUM_FILTERS-1:0]        hist_vld_q, hist_vld_d;

  logic [IDXW-1:0]               kidx;
  logic [IDXW-1:0]               load_idx;
  logic                          load_in_range;
  logic                          item_fire;
  logic                          coef_we;
  logic                          hist_we;
  logic [CWORD-1:0]              coef_wdata, coef_rdata, coef_word;
  logic [HWORD-1:0]              hist_wdata, hist_rdata, hist_word;
  logic signed [COEF_W-1:0]      g, f1, f2;
  logic signed [YW-1:0]          y1, y2, y_new;
  logic signed [AW-1:0]          mul_a;
  logic signed [BW-1:0]          mul_b;
  logic [CNTW-1:0]               k_next;
  logic [31:0]                   n_clamped;
  bbs_pkg::mac_ctrl_t            mac_ctrl;

  assign kidx          = k_q[IDXW-1:0];
  assign k_next        = k_q + CNTW'(1);
  assign load_idx      = IDXW'(item_i.filter_index);
  assign load_in_range = int'(item_i.filter_index) < NUM_FILTERS;

  // Take requests only while idle; configuration is always accepted.
  assign item_i.ready  = (state_q == ST_IDLE);
  assign item_fire     = item_i.valid && item_i.ready;
  assign cfg_i.ready   = 1'b1;

  assign result_o.valid    = out_valid_q;
  assign result_o.bank_sum = bank_sum_q;

  assign n_clamped = (int'(active_q) > NUM_FILTERS) ? 32'(NUM_FILTERS) : 32'(active_q);

  // Coefficient table: write on a load, read the current section.
  assign coef_we    = item_fire && (item_i.op == bbs_pkg::OP_LOAD) && load_in_range;
  assign coef_wdata = {item_i.coef_b0, item_i.coef_a1, item_i.coef_a2};

  bbs_ram #(
    .WIDTH (CWORD),
    .DEPTH (NUM_FILTERS)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (load_idx),
    .wdata_i (coef_wdata),
    .raddr_i (kidx),
    .rdata_o (coef_rdata)
  );

  // Output history: both taps live in one word and move together.
  assign hist_we    = (state_q == ST_FIN);
  assign hist_wdata = {y_new, y1};

  bbs_ram #(
    .WIDTH (HWORD),
    .DEPTH (NUM_FILTERS)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (kidx),
    .wdata_i (hist_wdata),
    .raddr_i (kidx),
    .rdata_o (hist_rdata)
  );

  // Entries never written since reset read as zero.
  assign coef_word = coef_vld_q[kidx] ? coef_rdata : '0;
  assign hist_word = hist_vld_q[kidx] ? hist_rdata : '0;

  assign g  = coef_word[CWORD-1 -: COEF_W];
  assign f1 = coef_word[2*COEF_W-1 -: COEF_W];
  assign f2 = coef_word[COEF_W-1:0];
  assign y1 = hist_word[HWORD-1 -: YW];
  assign y2 = hist_word[YW-1:0];

  // Operand select for the shared multiplier
  always_comb begin
    unique case (term_q)
      TERM_X: begin
        mul_a = AW'(g);
        mul_b = BW'(x_q);
      end
      TERM_X2: begin
        mul_a = -AW'(g);
        mul_b = BW'(xh2_q);
      end
      TERM_Y1: begin
        mul_a = AW'(f1);
        mul_b = y1;
      end
      TERM_Y2: begin
        mul_a = AW'(f2);
        mul_b = y2;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Multiply while a term is left; accumulate the product of the step before.
  // Feedback terms are subtracted.
  always_comb begin
    mac_ctrl.mul_en  = (state_q == ST_MAC) && (term_q != TERM_END);
    mac_ctrl.acc_clr = (state_q == ST_ADDR);
    mac_ctrl.acc_en  = (state_q == ST_MAC) && (term_q != TERM_X);
    mac_ctrl.acc_sub = (term_q == TERM_Y2) || (term_q == TERM_END);
  end

  bbs_mac #(
    .FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .op_a_i (mul_a),
    .op_b_i (mul_b),
    .y_o    (y_new)
  );

  // Sequencer
  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    n_d         = n_q;
    term_d      = term_q;
    x_d         = x_q;
    xh1_d       = xh1_q;
    xh2_d       = xh2_q;
    sum_d       = sum_q;
    out_valid_d = out_valid_q;
    bank_sum_d  = bank_sum_q;
    active_d    = active_q;
    coef_vld_d  = coef_vld_q;
    hist_vld_d  = hist_vld_q;

    // Drop the result once the consumer takes it.
    if (out_valid_q && result_o.ready) begin
      out_valid_d = 1'b0;
    end

    if (cfg_i.valid) begin
      active_d = cfg_i.data;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (item_fire) begin
          if (item_i.op == bbs_pkg::OP_LOAD) begin
            if (load_in_range) begin
              coef_vld_d[load_idx] = 1'b1;
            end
          end else begin
            x_d   = item_i.sample;
            n_d   = CNTW'(n_clamped);
            k_d   = '0;
            sum_d = '0;
            if (n_clamped == 32'd0) begin
              state_d = ST_DONE;
            end else begin
              state_d = ST_ADDR;
            end
          end
        end
      end
      ST_ADDR: begin
        term_d  = TERM_X;
        state_d = ST_MAC;
      end
      ST_MAC: begin
        if (term_q == TERM_END) begin
          state_d = ST_FIN;
        end else begin
          term_d = term_q + 3'd1;
        end
      end
      ST_FIN: begin
        hist_vld_d[kidx] = 1'b1;
        sum_d = sum_q + SACCW'(y_new);
        k_d   = k_next;
        if (k_next == n_q) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_ADDR;
        end
      end
      ST_DONE: begin
        // Hold until the output register is free, then advance input history.
        if (!out_valid_q || result_o.ready) begin
          out_valid_d = 1'b1;
          if (sum_q > SUM_MAX) begin
            bank_sum_d = SW'(SUM_MAX);
          end else if (sum_q < SUM_MIN) begin
            bank_sum_d = SW'(SUM_MIN);
          end else begin
            bank_sum_d = SW'(sum_q);
          end
          xh2_d   = xh1_q;
          xh1_d   = x_q;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      n_q         <= '0;
      term_q      <= TERM_X;
      xh1_q       <= '0;
      xh2_q       <= '0;
      out_valid_q <= 1'b0;
      active_q    <= bbs_pkg::ACTIVE_RESET;
      coef_vld_q  <= '0;
      hist_vld_q  <= '0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      n_q         <= n_d;
      term_q      <= term_d;
      xh1_q       <= xh1_d;
      xh2_q       <= xh2_d;
      out_valid_q <= out_valid_d;
      active_q    <= active_d;
      coef_vld_q  <= coef_vld_d;
      hist_vld_q  <= hist_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    sum_q      <= sum_d;
    bank_sum_q <= bank_sum_d;
  end

endmodule

`default_nettype wire

// ===== design/bbs_ram.sv =====
// ----------------------------------------------------------------------------
// bbs_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/bbs_mac.sv =====
// ----------------------------------------------------------------------------
// bbs_mac: shared multiply, round and accumulate unit
// Registers one product per step, rounds it half up and accumulates it.
// ----------------------------------------------------------------------------
`default_nettype none

module bbs_mac #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire bbs_pkg::mac_ctrl_t                   ctrl_i,
  input  wire logic signed [bbs_pkg::MUL_A_W-1:0]   op_a_i,
  input  wire logic signed [bbs_pkg::MUL_B_W-1:0]   op_b_i,
  output logic signed [bbs_pkg::YHIST_W-1:0]        y_o
);

  localparam int PW   = bbs_pkg::MUL_A_W + bbs_pkg::MUL_B_W;
  localparam int TW   = PW + 1 - FRAC_BITS;
  localparam int ACCW = TW + 2;
  localparam int YW   = bbs_pkg::YHIST_W;

  localparam logic [PW:0] HALF = {{PW{1'b0}}, 1'b1} << (FRAC_BITS - 1);
  localparam logic signed [ACCW-1:0] Y_MAX = ACCW'((64'sd1 <<< (YW - 1)) - 64'sd1);
  localparam logic signed [ACCW-1:0] Y_MIN = ACCW'(-(64'sd1 <<< (YW - 1)));

  logic signed [PW-1:0]   prod_q;
  logic signed [PW:0]     prod_rnd;
  logic signed [TW-1:0]   term;
  logic signed [ACCW-1:0] acc_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= PW'(op_a_i) * PW'(op_b_i);
    end
  end

  assign prod_rnd = $signed({prod_q[PW-1], prod_q}) + $signed(HALF);
  assign term     = TW'(prod_rnd >>> FRAC_BITS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctrl_i.acc_clr) begin
      acc_q <= '0;
    end else if (ctrl_i.acc_en) begin
      if (ctrl_i.acc_sub) begin
        acc_q <= acc_q - ACCW'(term);
      end else begin
        acc_q <= acc_q + ACCW'(term);
      end
    end
  end

  always_comb begin
    if (acc_q > Y_MAX) begin
      y_o = YW'(Y_MAX);
    end else if (acc_q < Y_MIN) begin
      y_o = YW'(Y_MIN);
    end else begin
      y_o = YW'(acc_q);
    end
  end

endmodule

`default_nettype wire
